// File: hdl/rsdz_pkg.sv
// ----------------------------------------------------------------------------
// rsdz_pkg
// Shared widths, constants, stage map and the stage word type for the
// radial stick dead zone core.
// ----------------------------------------------------------------------------
package rsdz_pkg;

  localparam int SW  = 16;   // sample width
  localparam int DZW = 15;   // dead zone register width
  localparam logic [DZW-1:0] DZ_RESET = 15'd5898;
  localparam logic [SW-1:0]  ONE      = 16'h8000;
  localparam logic [SW-1:0]  TOP      = 16'h7FFF;

  // stage map
  localparam int ST_SQR      = 0;
  localparam int ST_SUM      = 1;
  localparam int SQRT_FIRST  = 2;
  localparam int SQRT_LAST   = 17;
  localparam int ST_SETUP    = 18;
  localparam int DIV1_FIRST  = 19;
  localparam int DIV1_LAST   = 33;
  localparam int ST_PROD     = 34;
  localparam int DIV2_FIRST  = 35;
  localparam int DIV2_LAST   = 50;
  localparam int ST_FINAL    = 51;
  localparam int N_STG       = 52;

  typedef struct packed {
    logic          nx;
    logic          ny;
    logic [15:0]   ax;
    logic [15:0]   ay;
    logic [31:0]   sqa;
    logic [31:0]   sqb;
    logic [31:0]   sq;
    logic [17:0]   srem;
    logic [15:0]   root;
    logic          dzf;
    logic          sat;
    logic [15:0]   drem;
    logic [15:0]   dd;
    logic [14:0]   adj;
    logic [31:0]   px;
    logic [31:0]   py;
    logic [15:0]   rx;
    logic [15:0]   ry;
    logic [15:0]   qx;
    logic [15:0]   qy;
    logic [15:0]   ox;
    logic [15:0]   oy;
  } stage_t;

endpackage

// File: hdl/rsdz_if.sv
// ----------------------------------------------------------------------------
// rsdz_if
// Valid/ready channels: sample in, result out, dead zone write.
// ----------------------------------------------------------------------------
interface rsdz_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  modport source (output valid, axis_x, axis_y, input ready);
  modport sink   (input valid, axis_x, axis_y, output ready);
endinterface

interface rsdz_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               in_dead_zone;
  modport source (output valid, out_x, out_y, in_dead_zone, input ready);
  modport sink   (input valid, out_x, out_y, in_dead_zone, output ready);
endinterface

interface rsdz_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/rsdz_pipe.sv
// ----------------------------------------------------------------------------
// rsdz_pipe
// Stage chain: squares, sum, bit-per-stage root, dead zone test, remap divide, axis
// product, bit-per-stage axis divide, saturate and sign.
// ----------------------------------------------------------------------------
module rsdz_pipe import rsdz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic signed [SW-1:0]  in_x,
  input  logic signed [SW-1:0]  in_y,
  input  logic [DZW-1:0]        dz,
  output logic                  out_vld,
  output stage_t                out_st
);

  logic   [N_STG-1:0] vld_r;
  stage_t             st_r  [N_STG];
  stage_t             st_nxt[N_STG];

  function automatic stage_t f_sqrt(stage_t s);
    stage_t     r;
    logic [19:0] rem2;
    logic [19:0] trial;
    r     = s;
    rem2  = {s.srem, s.sq[31:30]};
    trial = {2'b00, s.root, 2'b01};
    if (rem2 >= trial) begin
      r.srem = 18'(rem2 - trial);
      r.root = {s.root[14:0], 1'b1};
    end else begin
      r.srem = rem2[17:0];
      r.root = {s.root[14:0], 1'b0};
    end
    r.sq = {s.sq[29:0], 2'b00};
    return r;
  endfunction

  function automatic stage_t f_div1(stage_t s);
    stage_t      r;
    logic [16:0] t;
    r = s;
    t = {s.drem, 1'b0};
    if (t >= {1'b0, s.dd}) begin
      r.drem = 16'(t - {1'b0, s.dd});
      r.adj  = {s.adj[13:0], 1'b1};
    end else begin
      r.drem = t[15:0];
      r.adj  = {s.adj[13:0], 1'b0};
    end
    return r;
  endfunction

  function automatic stage_t f_div2(stage_t s);
    stage_t      r;
    logic [16:0] tx;
    logic [16:0] ty;
    r  = s;
    tx = {s.rx, s.px[15]};
    ty = {s.ry, s.py[15]};
    r.px = {s.px[30:0], 1'b0};
    r.py = {s.py[30:0], 1'b0};
    if (tx >= {1'b0, s.root}) begin
      r.rx = 16'(tx - {1'b0, s.root});
      r.qx = {s.qx[14:0], 1'b1};
    end else begin
      r.rx = tx[15:0];
      r.qx = {s.qx[14:0], 1'b0};
    end
    if (ty >= {1'b0, s.root}) begin
      r.ry = 16'(ty - {1'b0, s.root});
      r.qy = {s.qy[14:0], 1'b1};
    end else begin
      r.ry = ty[15:0];
      r.qy = {s.qy[14:0], 1'b0};
    end
    return r;
  endfunction

  // entry: sign split and squares
  always_comb begin
    st_nxt[ST_SQR]     = '0;
    st_nxt[ST_SQR].nx  = in_x[SW-1];
    st_nxt[ST_SQR].ny  = in_y[SW-1];
    st_nxt[ST_SQR].ax  = in_x[SW-1] ? 16'(~in_x + 16'd1) : in_x;
    st_nxt[ST_SQR].ay  = in_y[SW-1] ? 16'(~in_y + 16'd1) : in_y;
    st_nxt[ST_SQR].sqa = st_nxt[ST_SQR].ax * st_nxt[ST_SQR].ax;
    st_nxt[ST_SQR].sqb = st_nxt[ST_SQR].ay * st_nxt[ST_SQR].ay;
  end

  always_comb begin
    st_nxt[ST_SUM]      = st_r[ST_SUM-1];
    st_nxt[ST_SUM].sq   = st_r[ST_SUM-1].sqa + st_r[ST_SUM-1].sqb;
    st_nxt[ST_SUM].srem = '0;
    st_nxt[ST_SUM].root = '0;
  end

  for (genvar k = SQRT_FIRST; k <= SQRT_LAST; k++) begin : g_sqrt
    always_comb st_nxt[k] = f_sqrt(st_r[k-1]);
  end

  // dead zone test; full-scale magnitude saturates the remap
  always_comb begin
    stage_t s;
    s = st_r[ST_SETUP-1];
    st_nxt[ST_SETUP]     = s;
    st_nxt[ST_SETUP].dzf = s.root <= {1'b0, dz};
    st_nxt[ST_SETUP].sat = s.root[15];
    st_nxt[ST_SETUP].dd  = 16'(ONE - {1'b0, dz});
    st_nxt[ST_SETUP].adj = '0;
    if (s.root <= {1'b0, dz} || s.root[15])
      st_nxt[ST_SETUP].drem = '0;
    else
      st_nxt[ST_SETUP].drem = 16'(s.root - {1'b0, dz});
  end

  for (genvar k = DIV1_FIRST; k <= DIV1_LAST; k++) begin : g_div1
    always_comb st_nxt[k] = f_div1(st_r[k-1]);
  end

  // first div2 stage takes its remainder from the product's upper half
  always_comb begin
    stage_t      s;
    logic [15:0] a;
    logic [31:0] prx;
    logic [31:0] pry;
    s   = st_r[ST_PROD-1];
    a   = s.sat ? ONE : {1'b0, s.adj};
    prx = s.ax * a;
    pry = s.ay * a;
    st_nxt[ST_PROD]    = s;
    st_nxt[ST_PROD].px = prx;
    st_nxt[ST_PROD].py = pry;
    st_nxt[ST_PROD].rx = prx[31:16];
    st_nxt[ST_PROD].ry = pry[31:16];
    st_nxt[ST_PROD].qx = '0;
    st_nxt[ST_PROD].qy = '0;
  end

  // dividend top half is below the magnitude, so the quotient fits 16 bits
  always_comb begin
    stage_t s;
    s = f_div2(st_r[DIV2_FIRST-1]);
    st_nxt[DIV2_FIRST] = s;
  end

  for (genvar k = DIV2_FIRST + 1; k <= DIV2_LAST; k++) begin : g_div2
    always_comb st_nxt[k] = f_div2(st_r[k-1]);
  end

  always_comb begin
    stage_t      s;
    logic [15:0] mx;
    logic [15:0] my;
    s  = st_r[ST_FINAL-1];
    mx = (s.qx > TOP) ? TOP : s.qx;
    my = (s.qy > TOP) ? TOP : s.qy;
    st_nxt[ST_FINAL]    = s;
    st_nxt[ST_FINAL].ox = s.dzf ? '0 : (s.nx ? 16'(~mx + 16'd1) : mx);
    st_nxt[ST_FINAL].oy = s.dzf ? '0 : (s.ny ? 16'(~my + 16'd1) : my);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_STG-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_STG; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign out_vld = vld_r[N_STG-1];
  assign out_st  = st_r[N_STG-1];

endmodule

// File: hdl/radial_stick_dead_zone_core.sv
// An accepted sample word moves through the whole stage chain to its result word.
// Throughput: one word per cycle while the output is not stalled; 16 root stages
//   and two long dividers (15 and 16 stages, one quotient bit each) set the depth.
// The whole chain advances when the output register is empty or taken.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
//   dead zone register with 5898 (0.18 of full scale).
// ----------------------------------------------------------------------------
// radial_stick_dead_zone_core
// Radial dead zone with rescale of the live range for a two-axis stick.
// ----------------------------------------------------------------------------
module radial_stick_dead_zone_core import rsdz_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rsdz_in_if.sink     in_ch,
  rsdz_out_if.source  out_ch,
  rsdz_cfg_if.sink    cfg_ch
);

  logic [DZW-1:0] dz_r;
  logic           en;
  logic           pipe_vld;
  stage_t         pipe_st;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r <= DZ_RESET;
    end else if (cfg_ch.valid) begin
      dz_r <= cfg_ch.data;
    end
  end

  assign en          = !pipe_vld || out_ch.ready;
  assign in_ch.ready = en;

  rsdz_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_ch.valid),
    .in_x    (in_ch.axis_x),
    .in_y    (in_ch.axis_y),
    .dz      (dz_r),
    .out_vld (pipe_vld),
    .out_st  (pipe_st)
  );

  assign out_ch.valid        = pipe_vld;
  assign out_ch.out_x        = pipe_st.ox;
  assign out_ch.out_y        = pipe_st.oy;
  assign out_ch.in_dead_zone = pipe_st.dzf;

endmodule

// File: hdl/rsdz_checker.sv
// ----------------------------------------------------------------------------
// rsdz_checker
// Port-level checks on the radial dead zone core, bound to the top level.
// ----------------------------------------------------------------------------
module rsdz_checker import rsdz_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic        out_dz
);

  // a held result word keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_dz))
    else $error("result word changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_x == 16'd0 && out_y == 16'd0)
    else $error("dead zone word with nonzero axes");

  a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_x != ONE && out_y != ONE)
    else $error("result reached negative full scale");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind radial_stick_dead_zone_core rsdz_checker u_rsdz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_dz    (out_ch.in_dead_zone)
);
